// ===== src/ple_pkg.sv =====
// shared types and constants of the pose linear extrapolator
package ple_pkg;

  localparam int NUM_CH    = 6;
  localparam int NUM_ANGLE = 3;
  localparam int CH_W      = $clog2(NUM_CH);
  localparam int DIV_BITS  = 64;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [31:0] MAX_HORIZON_RESET = 32'd100000;
  localparam logic [63:0] LIN_Q_LIMIT       = 64'h0000_0002_0000_0000;

  typedef struct packed {
    logic        start;
    logic [32:0] mag;
    logic [31:0] h;
    logic [63:0] dt;
  } ple_scale_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } ple_scale_rsp_t;

endpackage

// ===== src/ple_scale_unit.sv =====
// shared scale unit: round(mag * h / dt) by one multiply and a bit-serial divide
module ple_scale_unit
  import ple_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  ple_scale_req_t req,
  output ple_scale_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_BITS);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_RND} ustate_t;

  ustate_t            ustate;
  logic [32:0]        mag_r;
  logic [31:0]        h_r;
  logic [63:0]        dt_r;
  logic [63:0]        quo;
  logic [63:0]        rem;
  logic [CNT_W-1:0]   cnt;
  logic               done;
  logic [63:0]        q_r;

  logic [63:0]        prod;
  logic [64:0]        rem_sh;
  logic [64:0]        rem_sub;
  logic               ge;
  logic               rnd_up;

  // mag <= 2^32 and h < 2^32, so the product fits in 64 bits
  assign prod    = 64'(mag_r) * 64'(h_r);
  assign rem_sh  = {rem, quo[63]};
  assign ge      = rem_sh >= {1'b0, dt_r};
  assign rem_sub = rem_sh - {1'b0, dt_r};
  // ties go away from zero: 2r >= dt
  assign rnd_up  = {rem, 1'b0} >= {1'b0, dt_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      unique case (ustate)
        U_IDLE: begin
          if (req.start) begin
            mag_r  <= req.mag;
            h_r    <= req.h;
            dt_r   <= req.dt;
            ustate <= U_MUL;
          end
        end
        U_MUL: begin
          quo    <= prod;
          rem    <= '0;
          cnt    <= '0;
          ustate <= U_DIV;
        end
        U_DIV: begin
          rem <= ge ? rem_sub[63:0] : rem_sh[63:0];
          quo <= {quo[62:0], ge};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_BITS - 1)) begin
            ustate <= U_RND;
          end
        end
        U_RND: begin
          q_r    <= quo + {63'b0, rnd_up};
          done   <= 1'b1;
          ustate <= U_IDLE;
        end
        default: ustate <= U_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.q    = q_r;

endmodule

// ===== src/pose_linear_extrapolator_core.sv =====
// top level of the pose linear extrapolator: sample store, sequencer, output register
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | tuser action; tdata time, pan, tilt, roll, x, y, z
//  m_      | out | m_tvalid/m_tready | tuser pose_valid; tdata six pose fields, sample_count
//  cfg_    | in  | cfg_wen           | cfg_wdata max_horizon_us
//
// a push is done in the idle state; a stored-pose query goes straight to the write step
// an extrapolating query runs six channels through the one scale unit, each by
// one multiply, a 64-bit bit-serial divide and a rounding step
// rst is synchronous; it clears the sample count and sets max_horizon_us to 100000
// s_tready is low while a query is in work; the output register lets the next
// item in while a result waits, a later query waits for the register to free up
module pose_linear_extrapolator_core
  import ple_pkg::*;
#(
  parameter int RING_CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [255:0] s_tdata,   // time_us, pan_in, tilt_in, roll_in, x_in, y_in, z_in
  input  logic         s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata,   // pan_out, tilt_out, roll_out, x_out, y_out, z_out,
                                  // sample_count, zero fill
  output logic         m_tuser,   // pose_valid
  input  logic         cfg_wen,
  input  logic [31:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(RING_CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_WRITE} state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [31:0]        max_horizon;
  logic [63:0]        nw_time;
  logic [63:0]        pv_time;
  logic [31:0]        nw_pose [NUM_CH];
  logic [31:0]        pv_pose [NUM_CH];
  logic [31:0]        res_pose [NUM_CH];
  logic               res_valid;
  logic [CH_W-1:0]    ch;
  logic [31:0]        h_r;
  logic [63:0]        dt_r;

  ple_scale_req_t     req;
  ple_scale_rsp_t     rsp;

  logic               s_accept;
  logic [31:0]        cnt32;
  logic [4:0]         sc;
  logic [63:0]        tq;
  logic [63:0]        hfull;
  logic [31:0]        h_clamp;
  logic               extrap;
  logic [31:0]        a1;
  logic [31:0]        a0;
  logic               is_angle;
  logic [31:0]        diff32;
  logic [32:0]        d33;
  logic               neg;
  logic [32:0]        mag;
  logic [31:0]        angle_res;
  logic [33:0]        qs;
  logic [35:0]        r36;
  logic [31:0]        lin_res;
  logic [191:0]       pose_word;

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign cnt32    = 32'(count);
  assign sc       = (cnt32 > 32'd31) ? 5'd31 : cnt32[4:0];

  // query checks
  assign tq      = s_tdata[63:0];
  assign hfull   = tq - nw_time;
  assign h_clamp = (hfull > {32'b0, max_horizon}) ? max_horizon : hfull[31:0];
  assign extrap  = (cnt32 >= 32'd2) && (tq > nw_time) && (nw_time > pv_time);

  // per channel operands
  assign a1       = nw_pose[ch];
  assign a0       = pv_pose[ch];
  assign is_angle = ch < CH_W'(NUM_ANGLE);
  assign diff32   = a1 - a0;
  assign d33      = {a1[31], a1} - {a0[31], a0};

  always_comb begin
    if (is_angle) begin
      // short way round; the most negative step stays negative
      neg = diff32[31];
      mag = {1'b0, neg ? (~diff32 + 32'd1) : diff32};
    end else begin
      neg = d33[32];
      mag = neg ? (~d33 + 33'd1) : d33;
    end
  end

  assign angle_res = neg ? (a1 - rsp.q[31:0]) : (a1 + rsp.q[31:0]);
  assign qs        = (rsp.q > LIN_Q_LIMIT) ? LIN_Q_LIMIT[33:0] : rsp.q[33:0];
  assign r36       = neg ? ({{4{a1[31]}}, a1} - {2'b0, qs})
                         : ({{4{a1[31]}}, a1} + {2'b0, qs});

  always_comb begin
    if (r36[35:31] == 5'b00000 || r36[35:31] == 5'b11111) begin
      lin_res = r36[31:0];
    end else if (r36[35]) begin
      lin_res = 32'h8000_0000;
    end else begin
      lin_res = 32'h7FFF_FFFF;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      pose_word[32*i +: 32] = res_pose[i];
    end
  end

  assign req.start = (state == S_START);
  assign req.mag   = mag;
  assign req.h     = h_r;
  assign req.dt    = dt_r;

  ple_scale_unit u_scale (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      max_horizon <= MAX_HORIZON_RESET;
      m_tvalid    <= 1'b0;
      ch          <= '0;
    end else begin
      if (cfg_wen) begin
        max_horizon <= cfg_wdata;
      end
      // the write step sets m_tvalid itself
      if (m_tvalid && m_tready && state != S_WRITE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            if (s_tuser == ACT_PUSH) begin
              pv_time <= nw_time;
              nw_time <= tq;
              for (int i = 0; i < NUM_CH; i++) begin
                pv_pose[i] <= nw_pose[i];
                nw_pose[i] <= s_tdata[64 + 32*i +: 32];
              end
              if (cnt32 < 32'(RING_CAPACITY)) begin
                count <= count + CNT_W'(1);
              end
            end else begin
              h_r  <= h_clamp;
              dt_r <= nw_time - pv_time;
              ch   <= '0;
              if (count == '0) begin
                res_valid <= 1'b0;
                for (int i = 0; i < NUM_CH; i++) res_pose[i] <= '0;
                state <= S_WRITE;
              end else begin
                res_valid <= 1'b1;
                for (int i = 0; i < NUM_CH; i++) res_pose[i] <= nw_pose[i];
                state <= extrap ? S_START : S_WRITE;
              end
            end
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (rsp.done) begin
            res_pose[ch] <= is_angle ? angle_res : lin_res;
            if (ch == CH_W'(NUM_CH - 1)) begin
              state <= S_WRITE;
            end else begin
              ch    <= ch + CH_W'(1);
              state <= S_START;
            end
          end
        end
        S_WRITE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, sc, pose_word};
            m_tuser  <= res_valid;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    cnt32 <= 32'(RING_CAPACITY))
    else $error("sample count above ring capacity");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tuser == ACT_PUSH && cnt32 < 32'(RING_CAPACITY))
      |=> (count == $past(count) + CNT_W'(1)))
    else $error("push did not advance the sample count");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_WAIT))
    else $error("scale result arrived outside a wait step");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[196:192] == 5'd0))
    else $error("invalid pose item with nonzero sample count");
`endif

endmodule

// ===== sim/pose_linear_extrapolator_core_tb.sv =====
// self-checking testbench for pose_linear_extrapolator_core: directed and random pushes/queries
module pose_linear_extrapolator_core_tb;
  import ple_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_CAP = 16;

  typedef struct packed {
    logic             act;
    logic [63:0]      t;
    logic [5:0][31:0] ch;   // pan, tilt, roll, x, y, z from index 0 up
  } stim_item_t;

  typedef struct packed {
    logic [63:0]      t;
    logic [5:0][31:0] ch;
  } pose_sample_t;

  typedef struct packed {
    logic             vld;
    logic [5:0][31:0] ch;
    logic [4:0]       cnt;
  } pose_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [199:0] m_tdata;
  logic         m_tuser;
  logic         cfg_wen = 1'b0;
  logic [31:0]  cfg_wdata = '0;

  pose_linear_extrapolator_core #(.RING_CAPACITY(RING_CAP)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  pose_sample_t kept_new = '0;
  pose_sample_t kept_old = '0;
  int           kept_count = 0;
  logic [31:0]  horizon_limit;
  pose_result_t pose_expect[$];

  // stimulus side
  stim_item_t       pending_items[$];
  stim_item_t       cur_item;
  logic [63:0]      gen_t;
  logic [5:0][31:0] gen_pose;
  int               items_queued;
  int               items_accepted = 0, results_checked = 0;
  int               pushes = 0, queries = 0, extrapolated = 0, errors = 0;
  logic             item_taken = 1'b0;
  logic             idle_on;
  int               send_gap = 0, ready_gap = 0, stall_left = 0;
  logic             hold_done = 1'b0;
  pose_result_t     want;

  string ch_name[6] = '{"pan", "tilt", "roll", "x", "y", "z"};

  // round(mag * h / dt), ties away from zero
  function automatic logic [63:0] ratio_round(logic [63:0] mag, logic [63:0] h,
                                              logic [63:0] dt);
    logic [63:0] p, q, r;
    p = mag * h;
    q = p / dt;
    r = p % dt;
    if (r >= dt - r) q = q + 1;
    return q;
  endfunction

  function automatic void predict_pose(stim_item_t it);
    pose_result_t res;
    logic [63:0]  h, dt, mag, q;
    logic [31:0]  diff;
    longint       b, d, r;
    if (it.act == ACT_PUSH) begin
      kept_old   = kept_new;
      kept_new.t  = it.t;
      kept_new.ch = it.ch;
      if (kept_count < RING_CAP) kept_count++;
      pushes++;
      return;
    end
    queries++;
    res.cnt = (kept_count > 31) ? 5'd31 : 5'(kept_count);
    if (kept_count == 0) begin
      res.vld = 1'b0;
      res.ch  = '0;
    end else begin
      res.vld = 1'b1;
      res.ch  = kept_new.ch;
      if (kept_count > 1 && it.t > kept_new.t && kept_new.t > kept_old.t) begin
        extrapolated++;
        h = it.t - kept_new.t;
        if (h > {32'b0, horizon_limit}) h = {32'b0, horizon_limit};
        dt = kept_new.t - kept_old.t;
        // angles: shortest signed step, result wraps
        for (int c = 0; c < NUM_ANGLE; c++) begin
          diff = kept_new.ch[c] - kept_old.ch[c];
          mag  = diff[31] ? {32'b0, -diff} : {32'b0, diff};
          q    = ratio_round(mag, h, dt);
          res.ch[c] = diff[31] ? kept_new.ch[c] - q[31:0] : kept_new.ch[c] + q[31:0];
        end
        // positions: exact step, result saturates
        for (int c = NUM_ANGLE; c < NUM_CH; c++) begin
          b   = longint'(signed'(kept_new.ch[c]));
          d   = b - longint'(signed'(kept_old.ch[c]));
          mag = (d < 0) ? -d : d;
          q   = ratio_round(mag, h, dt);
          if (q > LIN_Q_LIMIT) q = LIN_Q_LIMIT;
          r = (d < 0) ? b - longint'(q) : b + longint'(q);
          if (r > 64'sd2147483647) r = 64'sd2147483647;
          if (r < -64'sd2147483648) r = -64'sd2147483648;
          res.ch[c] = r[31:0];
        end
      end
    end
    pose_expect.push_back(res);
  endfunction

  // accept side: predict on input items, check output items
  always @(posedge clk) begin
    item_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      predict_pose(cur_item);
      items_accepted++;
    end
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (pose_expect.size() == 0) begin
        $display("%0t: result with nothing expected: valid %0b data %h",
                 $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = pose_expect.pop_front();
        if (want.vld !== m_tuser) begin
          $display("%0t: pose_valid mismatch expected %0b actual %0b", $time, want.vld, m_tuser);
          errors++;
        end
        for (int c = 0; c < NUM_CH; c++) begin
          if (want.ch[c] !== m_tdata[32*c +: 32]) begin
            $display("%0t: %s mismatch expected %h actual %h",
                     $time, ch_name[c], want.ch[c], m_tdata[32*c +: 32]);
            errors++;
          end
        end
        if (want.cnt !== m_tdata[196:192]) begin
          $display("%0t: sample_count mismatch expected %0d actual %0d",
                   $time, want.cnt, m_tdata[196:192]);
          errors++;
        end
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !item_taken) begin
      // hold the offered item until it is taken
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      s_tvalid <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      send_gap <= $urandom_range(1, 15) - 1;
      s_tvalid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      cur_item = pending_items.pop_front();
      s_tdata  <= {cur_item.ch, cur_item.t};
      s_tuser  <= cur_item.act;
      s_tvalid <= 1'b1;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // receiver, with one long hold-off so the output register fills and input stalls
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!hold_done && results_checked >= 40) begin
      hold_done  <= 1'b1;
      stall_left <= 1200;
      m_tready   <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap <= ready_gap - 1;
      m_tready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      ready_gap <= $urandom_range(1, 15) - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic add_item(input logic act, input logic [63:0] t,
                          input logic [31:0] pan, input logic [31:0] tilt,
                          input logic [31:0] roll, input logic [31:0] x,
                          input logic [31:0] y, input logic [31:0] z);
    stim_item_t it;
    it.act = act;
    it.t   = t;
    it.ch  = {z, y, x, roll, tilt, pan};
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_random_items(input int n);
    stim_item_t it;
    int         sel, mode;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      for (int c = 0; c < NUM_CH; c++) it.ch[c] = $urandom;
      if (sel < 55) begin
        // well-formed push: later time, pose mostly moving from the last one, at times random
        it.act = ACT_PUSH;
        it.t   = gen_t + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 1 << 20)
                                                      : $urandom_range(1, 2000));
        for (int c = 0; c < NUM_CH; c++) begin
          mode = $urandom_range(0, 9);
          if (mode < 6)       it.ch[c] = gen_pose[c] + 32'($urandom_range(0, 4000) - 2000);
          else if (mode == 8) it.ch[c] = gen_pose[c] + {$urandom_range(0, 1) ? 8'hff : 8'h00,
                                                        24'($urandom)};
          else if (mode == 9) it.ch[c] = gen_pose[c];
        end
        gen_t    = it.t;
        gen_pose = it.ch;
      end else if (sel < 88) begin
        it.act = ACT_QUERY;
        mode   = $urandom_range(0, 9);
        if (mode < 7)       it.t = gen_t + $urandom_range(0, 3000);
        else if (mode < 9)  it.t = gen_t + $urandom_range(0, 200000);
        else                it.t = gen_t + ({$urandom, $urandom} >> $urandom_range(0, 63));
      end else if (sel < 94) begin
        // noise push: any time and pose, often breaks the time order
        it.act   = ACT_PUSH;
        it.t     = {$urandom, $urandom} >> $urandom_range(0, 40);
        gen_t    = it.t;
        gen_pose = it.ch;
      end else begin
        it.act = ACT_QUERY;
        it.t   = $urandom_range(0, 1) ? {$urandom, $urandom} : gen_t - $urandom_range(0, 50);
      end
      pending_items.push_back(it);
      items_queued++;
    end
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || pose_expect.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_horizon(input logic [31:0] v);
    @(negedge clk);
    cfg_wen       <= 1'b1;
    cfg_wdata     <= v;
    horizon_limit = v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    logic [31:0] phase_limit[5];
    logic        phase_idle[5];
    horizon_limit   = MAX_HORIZON_RESET;
    items_queued    = 0;
    idle_on         = 1'b1;
    gen_t           = 64'd100;
    gen_pose        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty store, single sample, wrap, saturation, clamps, ties, time order
    add_item(ACT_QUERY, 64'd5, '1, '1, '1, '1, '1, '1);
    add_item(ACT_PUSH, 64'd1000, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
             32'h7fff_ffff, 32'h8000_0000, 32'h0);
    add_item(ACT_QUERY, 64'd2000, '0, '0, '0, '0, '0, '0);
    add_item(ACT_PUSH, 64'd2000, 32'h8000_0001, 32'h7fff_ffff, 32'h8000_0000,
             32'h7fff_ff00, 32'h7fff_ffff, 32'h8000_0000);
    add_item(ACT_QUERY, 64'd2000, '0, '0, '0, '0, '0, '0);
    add_item(ACT_QUERY, 64'd1500, '0, '0, '0, '0, '0, '0);
    add_item(ACT_QUERY, 64'd3000, '0, '0, '0, '0, '0, '0);
    add_item(ACT_QUERY, 64'd2500, '0, '0, '0, '0, '0, '0);
    add_item(ACT_QUERY, 64'hffff_ffff_ffff_ffff, '0, '0, '0, '0, '0, '0);
    add_item(ACT_PUSH, 64'd1999, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f,
             32'hf0f0_f0f0, 32'h5555_5555, 32'haaaa_aaaa);
    add_item(ACT_QUERY, 64'd5000, '0, '0, '0, '0, '0, '0);
    add_item(ACT_PUSH, 64'd10, '0, '0, '0, '0, '0, '0);
    add_item(ACT_PUSH, 64'd12, 32'h1, 32'hffff_ffff, 32'h8000_0000,
             32'h1, 32'hffff_ffff, 32'h0001_0000);
    add_item(ACT_QUERY, 64'd13, '0, '0, '0, '0, '0, '0);
    add_item(ACT_QUERY, 64'd15, '0, '0, '0, '0, '0, '0);
    add_item(ACT_PUSH, 64'd0, 32'h4000_0000, 32'hc000_0000, 32'h0,
             32'h8000_0000, 32'h7fff_ffff, 32'h0);
    add_item(ACT_PUSH, 64'h8000_0000_0000_0000, 32'hc000_0000, 32'h4000_0000, 32'hffff_ffff,
             32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    add_item(ACT_QUERY, 64'h8000_0000_0000_0005, '0, '0, '0, '0, '0, '0);
    add_item(ACT_PUSH, 64'hffff_ffff_ffff_ffff, '1, '1, '1, '1, '1, '1);
    add_item(ACT_QUERY, 64'hffff_ffff_ffff_ffff, '0, '0, '0, '0, '0, '0);
    wait_drained();

    // random phases, each under its own horizon limit
    phase_limit = '{32'($urandom_range(1, 5000)), 32'h0, 32'hffff_ffff, $urandom,
                    MAX_HORIZON_RESET};
    phase_idle  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    for (int p = 0; p < 5; p++) begin
      write_horizon(phase_limit[p]);
      idle_on = phase_idle[p];
      queue_random_items(350);
      wait_drained();
    end
    repeat (100) @(negedge clk);

    $display("checked %0d results from %0d items: %0d pushes, %0d queries, %0d extrapolated",
             results_checked, items_accepted, pushes, queries, extrapolated);
    $display("horizon limit stepped through reset value, zero, all ones and random values");
    if (errors == 0) begin
      $display("pose_linear_extrapolator_core_tb: done, clean");
    end else begin
      $display("pose_linear_extrapolator_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d items accepted, %0d results pending",
             items_accepted, pose_expect.size());
    $display("pose_linear_extrapolator_core_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ple_pkg.sv
src/ple_scale_unit.sv
src/pose_linear_extrapolator_core.sv
sim/pose_linear_extrapolator_core_tb.sv
